// ----- hw/rtl/mono_to_stereo_fir_reflections_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stereo reflection filter
// Both macros sample on i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MONO_TO_STEREO_FIR_REFLECTIONS_DEFINES_SVH
`define MONO_TO_STEREO_FIR_REFLECTIONS_DEFINES_SVH

// same-cycle implication
`define MSFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/msfr_pkg.sv -----
// ----------------------------------------------------------------------------
// msfr_pkg
// Widths, codes and item types of the stereo reflection filter.
// ----------------------------------------------------------------------------
package msfr_pkg;

    localparam int MAX_TAPS   = 256;
    localparam int TAP_AW     = $clog2(MAX_TAPS);
    localparam int TC_W       = TAP_AW + 1;

    localparam int SMP_W      = 16;
    localparam int MODE_W     = 2;
    localparam int COEF_IDX_W = 8;

    localparam logic [MODE_W-1:0] MODE_AUDIO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COEF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAL_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFL_GAIN  = 3'd4;

    localparam int MIX_W    = 17;
    localparam int GAIN_W   = 16;
    localparam logic [MIX_W-1:0]  MIX_ONE  = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd16384;

    // datapath widths
    localparam int PROD_W  = 2 * SMP_W;
    localparam int ACC_W   = PROD_W + TAP_AW;
    localparam int XW      = ACC_W + 2;
    localparam int LO_W    = XW / 2;
    localparam int HI_W    = XW - LO_W;
    localparam int PLO_W   = LO_W + MIX_W;
    localparam int PHI_W   = HI_W + MIX_W + 1;
    localparam int PW      = XW + MIX_W + 1;
    localparam int MIX_SH  = 16;
    localparam int GAIN_SH = 14;
    localparam int OUT_SH  = 15;

    typedef struct packed {
        logic        [MODE_W-1:0]     mode;
        logic signed [SMP_W-1:0]      sample;
        logic        [COEF_IDX_W-1:0] coef_index;
        logic signed [SMP_W-1:0]      coef_left;
        logic signed [SMP_W-1:0]      coef_right;
        logic                         block_end;
    } t_in_item;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_out;
        logic signed [SMP_W-1:0] right_out;
        logic                    block_end_out;
    } t_out_item;

endpackage

// ----- hw/rtl/msfr_if.sv -----
// ----------------------------------------------------------------------------
// msfr_if
// Valid/ready channels of the stereo reflection filter.
// ----------------------------------------------------------------------------
interface msfr_in_if import msfr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface msfr_out_if import msfr_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface msfr_cfg_if import msfr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DW-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/mono_to_stereo_fir_reflections.sv -----
// ----------------------------------------------------------------------------
// mono_to_stereo_fir_reflections
// Two FIR filters (left, right) over one circular mono history, scaled by
// wet mix and optional reflection gain, saturated to 16 bits.
//
//   channel  dir  payload                                        items
//   i_in     in   mode, sample, coef_index, coef_left/right, blk  one per op
//   o_res    out  left_out, right_out, block_end_out             one per audio
//   i_cfg    in   index, data                                    one per write
//
// Coefficient write, history clear and unused mode stay idle. Audio item:
// ST_RUN, ST_MLO/MHI/MSUM (twice if balance on), ST_FIN; output off: ST_FIN.
// The loop reads one tap per cycle from the history and coefficient RAMs.
// Sync reset clears config (gain to GAIN_RST), pointer, history valid bits.
// o_res stall holds the finished item; the next is taken, held in ST_FIN.
// ----------------------------------------------------------------------------
`include "mono_to_stereo_fir_reflections_defines.svh"

module mono_to_stereo_fir_reflections import msfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msfr_in_if.sink     i_in,
    msfr_cfg_if.sink    i_cfg,
    msfr_out_if.source  o_res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_MLO  = 3'd2;
    localparam logic [2:0] ST_MHI  = 3'd3;
    localparam logic [2:0] ST_MSUM = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam logic signed [XW-1:0] SAT_HI = XW'(32767);
    localparam logic signed [XW-1:0] SAT_LO = XW'(-32768);

    logic [2:0]          r_state, n_state;

    // configuration
    logic                r_enable;
    logic [TC_W-1:0]     r_tap_count;
    logic [MIX_W-1:0]    r_mix_level;
    logic                r_bal_en;
    logic [GAIN_W-1:0]   r_refl_gain;

    // history and taps
    logic signed [SMP_W-1:0] r_hist_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]     r_hist_vld;
    logic [2*SMP_W-1:0]      r_tap_mem [MAX_TAPS];
    logic signed [SMP_W-1:0] r_hist_q;
    logic                    r_hvld_q;
    logic [2*SMP_W-1:0]      r_tap_q;

    logic [TAP_AW-1:0]   r_wp;
    logic [TAP_AW-1:0]   r_hptr;
    logic [TC_W-1:0]     r_cnt;
    logic [TC_W-1:0]     r_taps;
    logic                r_rd_vld;
    logic                r_prod_vld;
    logic                r_second;
    logic                r_blk;

    logic signed [PROD_W-1:0] r_prod [2];
    logic signed [ACC_W-1:0]  r_acc  [2];
    logic signed [XW-1:0]     r_x    [2];
    logic [MIX_W-1:0]         r_m;
    logic [PLO_W-1:0]         r_plo  [2];
    logic signed [PHI_W-1:0]  r_phi  [2];

    logic                r_out_vld;
    t_out_item           r_out;

    logic                in_acc, cfg_acc, hist_we, tap_we, issue, out_on, slot_free;
    logic [TC_W-1:0]     n_taps;
    logic [MIX_W-1:0]    n_mix;
    logic signed [SMP_W-1:0] smp;
    logic signed [PW-1:0]    full  [2];
    logic signed [PW-1:0]    shd   [2];
    logic signed [XW-1:0]    q     [2];
    logic signed [SMP_W-1:0] n_sat [2];

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign hist_we     = in_acc && (i_in.data.mode == MODE_AUDIO);
    assign tap_we      = in_acc && (i_in.data.mode == MODE_COEF);
    assign issue       = (r_state == ST_RUN) && (r_cnt < r_taps);
    assign slot_free   = !r_out_vld || o_res.ready;

    assign n_taps = (r_tap_count > TC_W'(MAX_TAPS)) ? TC_W'(MAX_TAPS) : r_tap_count;
    assign n_mix  = (r_mix_level > MIX_ONE) ? MIX_ONE : r_mix_level;
    assign out_on = r_enable && (n_taps != '0) && (n_mix != '0);

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (hist_we) n_state = out_on ? ST_RUN : ST_FIN;
            end
            ST_RUN: begin
                if (!issue && !r_rd_vld && !r_prod_vld) n_state = ST_MLO;
            end
            ST_MLO:  n_state = ST_MHI;
            ST_MHI:  n_state = ST_MSUM;
            ST_MSUM: begin
                n_state = (!r_second && r_bal_en) ? ST_MLO : ST_FIN;
            end
            ST_FIN: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_enable    <= 1'b0;
            r_tap_count <= '0;
            r_mix_level <= '0;
            r_bal_en    <= 1'b0;
            r_refl_gain <= GAIN_RST;
            r_wp        <= '0;
            r_hptr      <= '0;
            r_cnt       <= '0;
            r_taps      <= '0;
            r_rd_vld    <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_second    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                case (i_cfg.index)
                    CFG_ENABLE:     r_enable    <= i_cfg.data[0];
                    CFG_TAP_COUNT:  r_tap_count <= i_cfg.data[TC_W-1:0];
                    CFG_MIX_LEVEL:  r_mix_level <= i_cfg.data[MIX_W-1:0];
                    CFG_BAL_ENABLE: r_bal_en    <= i_cfg.data[0];
                    CFG_REFL_GAIN:  r_refl_gain <= i_cfg.data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                case (i_in.data.mode)
                    MODE_AUDIO: begin
                        r_wp   <= r_wp + 1'b1;
                        r_hptr <= r_wp;
                        r_cnt  <= '0;
                        r_taps <= n_taps;
                    end
                    MODE_CLEAR: r_wp <= '0;
                    default: ;
                endcase
            end
            if (issue) begin
                r_cnt  <= r_cnt + 1'b1;
                r_hptr <= r_hptr - 1'b1;
            end
            r_rd_vld   <= issue;
            r_prod_vld <= r_rd_vld;
            if (r_state == ST_RUN) begin
                r_second <= 1'b0;
            end else if (r_state == ST_MSUM && n_state == ST_MLO) begin
                r_second <= 1'b1;
            end
            if (r_state == ST_FIN && slot_free) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // history valid bits: an entry never written since clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (in_acc && i_in.data.mode == MODE_CLEAR) begin
            r_hist_vld <= '0;
        end else if (hist_we) begin
            r_hist_vld[r_wp] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) r_hist_mem[r_wp] <= i_in.data.sample;
        r_hist_q <= r_hist_mem[r_hptr];
        r_hvld_q <= r_hist_vld[r_hptr];
    end

    always_ff @(posedge i_clk) begin
        if (tap_we) r_tap_mem[i_in.data.coef_index] <= {i_in.data.coef_left,
                                                         i_in.data.coef_right};
        r_tap_q <= r_tap_mem[r_cnt[TAP_AW-1:0]];
    end

    assign smp = r_hvld_q ? r_hist_q : '0;

    // partial products combine: signed high half shifted over unsigned low half
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            full[c] = $signed(PW'(r_phi[c]) <<< LO_W) + $signed(PW'(r_plo[c]));
            shd[c]  = r_second ? (full[c] >>> GAIN_SH) : (full[c] >>> MIX_SH);
            q[c]    = r_x[c] >>> OUT_SH;
            if (q[c] > SAT_HI) begin
                n_sat[c] = SAT_HI[SMP_W-1:0];
            end else if (q[c] < SAT_LO) begin
                n_sat[c] = SAT_LO[SMP_W-1:0];
            end else begin
                n_sat[c] = q[c][SMP_W-1:0];
            end
        end
    end

    // datapath, lane 0 left, lane 1 right
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_blk <= i_in.data.block_end;
            for (int c = 0; c < 2; c++) begin
                r_acc[c] <= '0;
                r_x[c]   <= '0;
            end
        end
        if (r_rd_vld) begin
            r_prod[0] <= smp * $signed(r_tap_q[2*SMP_W-1:SMP_W]);
            r_prod[1] <= smp * $signed(r_tap_q[SMP_W-1:0]);
        end
        if (r_prod_vld) begin
            for (int c = 0; c < 2; c++) r_acc[c] <= r_acc[c] + ACC_W'(r_prod[c]);
        end
        if (r_state == ST_RUN && n_state == ST_MLO) begin
            r_m <= n_mix;
            for (int c = 0; c < 2; c++) r_x[c] <= XW'(r_acc[c]);
        end
        if (r_state == ST_MLO) begin
            for (int c = 0; c < 2; c++) r_plo[c] <= r_x[c][LO_W-1:0] * r_m;
        end
        if (r_state == ST_MHI) begin
            for (int c = 0; c < 2; c++) begin
                r_phi[c] <= $signed(r_x[c][XW-1:LO_W]) * $signed({1'b0, r_m});
            end
        end
        if (r_state == ST_MSUM) begin
            for (int c = 0; c < 2; c++) r_x[c] <= shd[c][XW-1:0];
            r_m <= MIX_W'(r_refl_gain);
        end
        if (r_state == ST_FIN && slot_free) begin
            r_out.left_out      <= n_sat[0];
            r_out.right_out     <= n_sat[1];
            r_out.block_end_out <= r_blk;
        end
    end

    `MSFR_ASSERT_IMP(a_prod_in_run, r_prod_vld, r_state == ST_RUN,
        "tap products pending outside the tap loop")
    `MSFR_ASSERT_IMP(a_cnt_bound, r_state == ST_RUN, r_cnt <= r_taps,
        "tap counter ran past the tap count")
    `MSFR_ASSERT_NXT(a_off_to_fin, hist_we && !out_on, r_state == ST_FIN,
        "disabled audio item did not go straight to output")
    `MSFR_ASSERT_NXT(a_fin_emits, r_state == ST_FIN && slot_free,
        r_out_vld && r_state == ST_IDLE, "finished item not placed in output register")
    `MSFR_ASSERT_NXT(a_clear, in_acc && i_in.data.mode == MODE_CLEAR,
        r_wp == '0 && r_hist_vld == '0, "history clear incomplete")

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Stereo reflection filter testbench
// Drives mono samples, coefficient writes and history clears into the block
// with random gaps and output stalls. A local copy of the two FIR filters
// predicts every stereo item, which is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import msfr_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 3'd7;
    localparam int                   IDLE_TAIL     = 16;
    localparam int                   END_TAIL      = 32;
    localparam int                   RAND_PHASES   = 24;
    localparam int                   PHASE_ITEMS   = 67;
    localparam int unsigned          LIMIT_CYCLES  = 3_000_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    msfr_in_if  in_ch ();
    msfr_cfg_if cfg_ch ();
    msfr_out_if res_ch ();

    mono_to_stereo_fir_reflections DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always #1 i_clk = ~i_clk;

    // local copy of the filter state and registers
    logic                    cfg_on   = 1'b0;
    logic [TC_W-1:0]         cfg_taps = '0;
    logic [MIX_W-1:0]        cfg_mix  = '0;
    logic                    cfg_bal  = 1'b0;
    logic [GAIN_W-1:0]       cfg_gain = GAIN_RST;
    logic signed [SMP_W-1:0] echo_hist [MAX_TAPS];
    logic [TAP_AW-1:0]       hist_ptr = '0;
    logic signed [SMP_W-1:0] tap_l [MAX_TAPS];
    logic signed [SMP_W-1:0] tap_r [MAX_TAPS];

    t_out_item   expected_refl [$];
    int          src_max_gap = 9;
    int          snk_max_gap = 9;
    int          error_count = 0;
    int          n_audio, n_coef, n_clear, n_unused, n_results, n_cfg_writes;
    int unsigned cycle_count = 0;

    initial begin
        foreach (echo_hist[i]) echo_hist[i] = '0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < 40)
            $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DW-1:0] val);
        case (idx)
            CFG_ENABLE:     cfg_on   = val[0];
            CFG_TAP_COUNT:  cfg_taps = val[TC_W-1:0];
            CFG_MIX_LEVEL:  cfg_mix  = val[MIX_W-1:0];
            CFG_BAL_ENABLE: cfg_bal  = val[0];
            CFG_REFL_GAIN:  cfg_gain = val[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    // mix, optional gain, Q30 -> Q15, saturate; >>> on longint floors
    function automatic logic signed [SMP_W-1:0] scale_sat(input longint acc, input int mix);
        longint v;
        v = (acc * longint'(mix)) >>> MIX_SH;
        if (cfg_bal)
            v = (v * longint'(cfg_gain)) >>> GAIN_SH;
        v = v >>> OUT_SH;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[SMP_W-1:0];
    endfunction

    function automatic bit predict_reflection(input t_in_item it, output t_out_item res);
        int                taps;
        int                mix;
        longint            lacc;
        longint            racc;
        logic [TAP_AW-1:0] h;
        res = '0;
        case (it.mode)
            MODE_COEF: begin
                tap_l[it.coef_index] = it.coef_left;
                tap_r[it.coef_index] = it.coef_right;
                return 1'b0;
            end
            MODE_CLEAR: begin
                foreach (echo_hist[i]) echo_hist[i] = '0;
                hist_ptr = '0;
                return 1'b0;
            end
            MODE_AUDIO: begin
                echo_hist[hist_ptr] = it.sample;
                taps = (cfg_taps > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
                mix  = (cfg_mix > MIX_ONE) ? int'(MIX_ONE) : int'(cfg_mix);
                if (cfg_on && taps > 0 && mix > 0) begin
                    lacc = 0;
                    racc = 0;
                    h    = hist_ptr;
                    for (int t = 0; t < taps; t++) begin
                        lacc += longint'(echo_hist[h]) * longint'(tap_l[t]);
                        racc += longint'(echo_hist[h]) * longint'(tap_r[t]);
                        h = h - 1'b1;   // wraps to MAX_TAPS-1
                    end
                    res.left_out  = scale_sat(lacc, mix);
                    res.right_out = scale_sat(racc, mix);
                end
                res.block_end_out = it.block_end;
                hist_ptr = hist_ptr + 1'b1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic signed [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // unused fields carry noise; the block must ignore them
    function automatic t_in_item make_item(input logic [MODE_W-1:0] mode);
        t_in_item it;
        it.mode       = mode;
        it.sample     = SMP_W'($urandom);
        it.coef_index = COEF_IDX_W'($urandom);
        it.coef_left  = SMP_W'($urandom);
        it.coef_right = SMP_W'($urandom);
        it.block_end  = 1'($urandom);
        return it;
    endfunction

    function automatic t_in_item audio_item(input logic signed [SMP_W-1:0] smp,
                                            input logic blk);
        t_in_item it;
        it           = make_item(MODE_AUDIO);
        it.sample    = smp;
        it.block_end = blk;
        return it;
    endfunction

    function automatic t_in_item coef_item(input logic [COEF_IDX_W-1:0] idx,
                                           input logic signed [SMP_W-1:0] cl,
                                           input logic signed [SMP_W-1:0] cr);
        t_in_item it;
        it            = make_item(MODE_COEF);
        it.coef_index = idx;
        it.coef_left  = cl;
        it.coef_right = cr;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int        gap;
        t_out_item res;
        gap = $urandom_range(0, src_max_gap);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        if (predict_reflection(it, res))
            expected_refl.push_back(res);
        case (it.mode)
            MODE_AUDIO: n_audio++;
            MODE_COEF:  n_coef++;
            MODE_CLEAR: n_clear++;
            default:    n_unused++;
        endcase
    endtask

    // wait until every expected item is out and the block has gone quiet
    task automatic settle_block();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_refl.size() != 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_reg(idx, val);
        n_cfg_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // result side: random stall before each item
    initial begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, snk_max_gap);
            @(negedge i_clk);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            if (expected_refl.size() == 0) begin
                report_mismatch("unexpected item", int'(res_ch.data.left_out), 0);
            end else begin
                want = expected_refl.pop_front();
                if (res_ch.data.left_out !== want.left_out)
                    report_mismatch("left_out", int'(res_ch.data.left_out),
                                    int'(want.left_out));
                if (res_ch.data.right_out !== want.right_out)
                    report_mismatch("right_out", int'(res_ch.data.right_out),
                                    int'(want.right_out));
                if (res_ch.data.block_end_out !== want.block_end_out)
                    report_mismatch("block_end_out", int'(res_ch.data.block_end_out),
                                    int'(want.block_end_out));
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= LIMIT_CYCLES);
        $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
        $display("testbench: errors");
        $finish;
    end

    // out of reset the block is off: zeros out, history still fills
    task automatic test_output_off();
        send_item(audio_item(16'sh7FFF, 1'b1));
        send_item(audio_item(16'sh8000, 1'b0));
        send_item(make_item(MODE_UNUSED));
        send_item(audio_item(16'sh0000, 1'b1));
    endtask

    // every tap gets written before any is read
    task automatic test_tap_load();
        for (int i = 0; i < MAX_TAPS; i++) begin
            if (i == 0)
                send_item(coef_item(COEF_IDX_W'(i), 16'sh8000, 16'sh7FFF));
            else if (i == MAX_TAPS - 1)
                send_item(coef_item(COEF_IDX_W'(i), 16'sh7FFF, 16'sh8000));
            else
                send_item(coef_item(COEF_IDX_W'(i), rand_sample(), rand_sample()));
        end
    endtask

    // full-scale taps against full-scale samples drive both rails
    task automatic test_saturation();
        for (int i = 0; i < 4; i++)
            send_item(coef_item(COEF_IDX_W'(i), 16'sh8000, 16'sh7FFF));
        settle_block();
        write_reg(CFG_ENABLE, 1);
        write_reg(CFG_TAP_COUNT, 4);
        write_reg(CFG_MIX_LEVEL, MIX_ONE);
        write_reg(CFG_BAL_ENABLE, 0);
        repeat (4) send_item(audio_item(16'sh8000, 1'b0));
        send_item(audio_item(16'sh7FFF, 1'b1));
        send_item(audio_item(16'sh7FFF, 1'b0));
    endtask

    task automatic test_gain_and_mix();
        settle_block();
        write_reg(CFG_BAL_ENABLE, 1);
        write_reg(CFG_REFL_GAIN, 17'hFFFF);
        send_item(audio_item(16'sh7FFF, 1'b1));
        send_item(audio_item(16'sh8000, 1'b0));
        settle_block();
        write_reg(CFG_REFL_GAIN, 0);
        send_item(audio_item(16'sh7FFF, 1'b0));
        settle_block();
        write_reg(CFG_BAL_ENABLE, 0);
        write_reg(CFG_MIX_LEVEL, 1);
        send_item(audio_item(16'sh8000, 1'b1));
        // oversized mix and tap count clamp to unity and MAX_TAPS
        settle_block();
        write_reg(CFG_MIX_LEVEL, 17'h1FFFF);
        write_reg(CFG_TAP_COUNT, CFG_DW'(9'h1FF));
        send_item(audio_item(rand_sample(), 1'b0));
        settle_block();
        write_reg(CFG_TAP_COUNT, 0);
        send_item(audio_item(16'sh7FFF, 1'b1));
        settle_block();
        write_reg(CFG_TAP_COUNT, 8);
        write_reg(CFG_MIX_LEVEL, 0);
        send_item(audio_item(16'sh8000, 1'b0));
        // unknown register index must leave everything alone
        settle_block();
        write_reg(CFG_UNUSED, 17'h1FFFF);
        write_reg(CFG_MIX_LEVEL, MIX_ONE);
        write_reg(CFG_REFL_GAIN, CFG_DW'(GAIN_RST));
        write_reg(CFG_BAL_ENABLE, 1);
        send_item(audio_item(16'sh4000, 1'b1));
    endtask

    // tap writes keep the history, a clear wipes history and pointer only
    task automatic test_history_clear();
        send_item(audio_item(16'sh1234, 1'b0));
        send_item(coef_item(8'd2, rand_sample(), rand_sample()));
        send_item(audio_item(16'shFFFF, 1'b0));
        send_item(make_item(MODE_CLEAR));
        send_item(audio_item(16'sh7FFF, 1'b1));
        send_item(make_item(MODE_UNUSED));
        send_item(audio_item(16'sh8000, 1'b0));
    endtask

    task automatic test_random_traffic();
        int sel;
        for (int p = 0; p < RAND_PHASES; p++) begin
            settle_block();
            write_reg(CFG_ENABLE, CFG_DW'($urandom_range(0, 9) != 0));
            sel = $urandom_range(0, 19);
            case (sel)
                0:       write_reg(CFG_TAP_COUNT, 0);
                1:       write_reg(CFG_TAP_COUNT, CFG_DW'(MAX_TAPS));
                2:       write_reg(CFG_TAP_COUNT, CFG_DW'($urandom_range(MAX_TAPS + 1, 511)));
                default: write_reg(CFG_TAP_COUNT, CFG_DW'($urandom_range(1, 24)));
            endcase
            sel = $urandom_range(0, 9);
            case (sel)
                0:       write_reg(CFG_MIX_LEVEL, 0);
                1:       write_reg(CFG_MIX_LEVEL, MIX_ONE);
                2:       write_reg(CFG_MIX_LEVEL, CFG_DW'($urandom_range(65537, 131071)));
                3:       write_reg(CFG_MIX_LEVEL, CFG_DW'($urandom_range(1, 255)));
                default: write_reg(CFG_MIX_LEVEL, CFG_DW'($urandom_range(1, 65535)));
            endcase
            write_reg(CFG_BAL_ENABLE, CFG_DW'($urandom_range(0, 1)));
            sel = $urandom_range(0, 9);
            case (sel)
                0:       write_reg(CFG_REFL_GAIN, 0);
                1:       write_reg(CFG_REFL_GAIN, 17'hFFFF);
                2:       write_reg(CFG_REFL_GAIN, CFG_DW'(GAIN_RST));
                default: write_reg(CFG_REFL_GAIN, CFG_DW'(GAIN_W'($urandom)));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, CFG_DW'($urandom));
            // some phases run back to back on one or both sides
            src_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
            snk_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 80)
                    send_item(audio_item(rand_sample(), 1'($urandom)));
                else if (sel < 92)
                    send_item(coef_item(COEF_IDX_W'($urandom), rand_sample(), rand_sample()));
                else if (sel < 96)
                    send_item(make_item(MODE_CLEAR));
                else
                    send_item(make_item(MODE_UNUSED));
                if ($urandom_range(0, 99) == 0)
                    settle_block();
            end
        end
        src_max_gap = 9;
        snk_max_gap = 9;
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_output_off();
        test_tap_load();
        test_saturation();
        test_gain_and_mix();
        test_history_clear();
        test_random_traffic();

        settle_block();
        repeat (END_TAIL) @(posedge i_clk);
        if (expected_refl.size() != 0)
            report_mismatch("items never delivered", 0, expected_refl.size());

        $display("covered %0d audio, %0d tap writes, %0d clears, %0d unused-mode items",
                 n_audio, n_coef, n_clear, n_unused);
        $display("checked %0d stereo items over %0d register writes, %0d mismatches",
                 n_results, n_cfg_writes, error_count);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/msfr_pkg.sv
hw/rtl/msfr_if.sv
hw/rtl/mono_to_stereo_fir_reflections.sv
sim/testbench.sv
